// File: rtl/merge_sort_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the merge sort engine
// Concurrent checks clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_CORE_ASSERT_SVH
`define MERGE_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// Shared constants, types and control bundle for the merge sort engine.
// ---------------------------------------------------------------------------
package mse_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic insert;
		logic shift_out;
	} ctl_t;

endpackage

// File: rtl/mse_in_if.sv
// ---------------------------------------------------------------------------
// mse_in_if
// Input channel: one element word per handshake.
// ---------------------------------------------------------------------------
interface mse_in_if;
	logic          valid;
	logic          ready;
	mse_pkg::data_t value;
	logic          is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

// File: rtl/mse_out_if.sv
// ---------------------------------------------------------------------------
// mse_out_if
// Output channel: one sorted word per handshake.
// ---------------------------------------------------------------------------
interface mse_out_if;
	logic          valid;
	logic          ready;
	mse_pkg::data_t sorted_value;
	logic          is_final;
	logic          overflow;

	modport source (output valid, output sorted_value, output is_final, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input is_final, input overflow,
		output ready);
endinterface

// File: rtl/mse_cell.sv
// ---------------------------------------------------------------------------
// mse_cell
// One slot of the sorting row: holds a value, takes the new word, its left
// neighbor, or its right neighbor, depending on the broadcast command.
// ---------------------------------------------------------------------------
module mse_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  mse_pkg::ctl_t  ctl,
	input  mse_pkg::data_t new_val,
	input  mse_pkg::data_t left_val,
	input  logic           left_valid,
	input  logic           left_gt,
	input  mse_pkg::data_t right_val,
	input  logic           right_valid,
	output mse_pkg::data_t val,
	output logic           valid,
	output logic           gt
);

	mse_pkg::data_t val_q;
	logic           valid_q;

	// empty slot or strictly greater: new word goes in front of it (ties stay ahead)
	assign gt    = !valid_q || (val_q > new_val);
	assign val   = val_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_out) begin
			valid_q <= right_valid;
		end else if (ctl.insert) begin
			if (left_gt) begin
				valid_q <= left_valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_out) begin
			val_q <= right_val;
		end else if (ctl.insert) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end
	end

endmodule

// File: rtl/mse_ctrl.sv
// ---------------------------------------------------------------------------
// mse_ctrl
// Load/drain sequencer: element count, overflow flag and channel handshakes.
// ---------------------------------------------------------------------------
`include "merge_sort_engine_core_assert.svh"

module mse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_is_last,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output logic          is_final,
	output logic          overflow,
	output mse_pkg::ctl_t ctl
);

	mse_pkg::state_t state_q, state_d;
	mse_pkg::cnt_t   count_q;
	logic            ovf_q;
	logic            in_acc;
	logic            full;

	assign full   = (count_q == mse_pkg::cnt_t'(mse_pkg::CAPACITY));
	assign in_acc = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mse_pkg::ST_LOAD: begin
				if (in_acc && in_is_last) state_d = mse_pkg::ST_DRAIN;
			end
			mse_pkg::ST_DRAIN: begin
				if (out_ready && is_final) state_d = mse_pkg::ST_LOAD;
			end
			default: state_d = mse_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			mse_pkg::ST_LOAD:  in_ready  = 1'b1;
			mse_pkg::ST_DRAIN: out_valid = 1'b1;
			default: ;
		endcase
		is_final      = out_valid && (count_q == mse_pkg::cnt_t'(1));
		overflow      = ovf_q;
		ctl.insert    = in_acc && !full;
		ctl.shift_out = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.insert) begin
				count_q <= count_q + mse_pkg::cnt_t'(1);
			end else if (ctl.shift_out) begin
				count_q <= count_q - mse_pkg::cnt_t'(1);
			end
			if (in_acc && full) begin
				ovf_q <= 1'b1;
			end else if (ctl.shift_out && is_final) begin
				ovf_q <= 1'b0;
			end
		end
	end

	`MSE_ASSERT_NOW(a_excl_sides, 1'b1, !(in_ready && out_valid), "load and drain overlap")
	`MSE_ASSERT_NOW(a_drain_nonempty, out_valid, count_q != '0, "draining an empty row")
	`MSE_ASSERT_NOW(a_cnt_range, 1'b1, count_q <= mse_pkg::cnt_t'(mse_pkg::CAPACITY),
		"count beyond capacity")
	`MSE_ASSERT_NEXT(a_last_starts, in_acc && in_is_last, out_valid, "last word did not start drain")
	`MSE_ASSERT_NEXT(a_final_ends, out_valid && out_ready && is_final,
		in_ready && count_q == '0 && !ovf_q, "batch state not cleared after final word")

endmodule

// File: rtl/merge_sort_engine_core.sv
// ---------------------------------------------------------------------------
// merge_sort_engine_core
// Batch sorter for signed 32-bit words built as a row of compare cells.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch  : element words (value, is_last), valid/ready. A word is taken on
//           every cycle while the engine is loading.
//           Each word is placed straight into its sorted slot by the cell
//           row (stable: equal words keep arrival order).
//  out_ch : sorted words (sorted_value, is_final, overflow), smallest first.
//           is_final marks the last word of the batch.
//  Timing : the first sorted word is valid the cycle after the is_last word
//           is taken. The batch then drains at one word per cycle while
//           out_ch.ready is high; loading and draining never overlap.
//  in_ch.ready is low during drain; the next batch starts after the final
//           word is taken.
//  Capacity is mse_pkg::CAPACITY words. Words arriving with the row full
//           are dropped (a dropped is_last word still ends the batch) and
//           every word of that batch leaves with overflow set.
//  Stall: while out_ch.ready is low the row holds still and the head cell,
//           which is a register, keeps presenting the same word.
//  Reset: arst_n empties the row and clears count and overflow; no clearing
//           pass is needed, since empty slots are tracked by valid bits.
// ---------------------------------------------------------------------------
module merge_sort_engine_core (
	input  logic      clk,
	input  logic      arst_n,
	mse_in_if.sink    in_ch,
	mse_out_if.source out_ch
);

	localparam int N = mse_pkg::CAPACITY;

	mse_pkg::ctl_t  ctl;
	mse_pkg::data_t cell_val   [N];
	logic           cell_valid [N];
	logic           cell_gt    [N];
	logic           in_ready;
	logic           out_valid;
	logic           is_final;
	logic           overflow;

	mse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_is_last (in_ch.is_last),
		.in_ready   (in_ready),
		.out_ready  (out_ch.ready),
		.out_valid  (out_valid),
		.is_final   (is_final),
		.overflow   (overflow),
		.ctl        (ctl)
	);

	// cell row: slot 0 holds the smallest word and feeds the output
	for (genvar i = 0; i < N; i++) begin : g_cell
		mse_pkg::data_t l_val, r_val;
		logic           l_valid, l_gt, r_valid;

		if (i == 0) begin : g_head
			assign l_val   = '0;
			assign l_valid = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_mid
			assign l_val   = cell_val[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign r_val   = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_val   = cell_val[i+1];
			assign r_valid = cell_valid[i+1];
		end

		mse_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_val     (in_ch.value),
			.left_val    (l_val),
			.left_valid  (l_valid),
			.left_gt     (l_gt),
			.right_val   (r_val),
			.right_valid (r_valid),
			.val         (cell_val[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i])
		);
	end

	assign in_ch.ready         = in_ready;
	assign out_ch.valid        = out_valid;
	assign out_ch.sorted_value = cell_val[0];
	assign out_ch.is_final     = is_final;
	assign out_ch.overflow     = overflow;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for merge_sort_engine_core. Words go in on in_ch in
// batches closed by is_last. A predictor keeps its own copy of the held batch
// and sorts it bottom-up when the batch closes. Every word taken on out_ch is
// checked, field by field, against the oldest sorted word still due.
// ---------------------------------------------------------------------------
module testbench;

	localparam int             LIMIT        = 500000;
	localparam int             RANDOM_WORDS = 90;
	// drain of a full row plus a margin
	localparam int             DRAIN_SLACK  = 2 * mse_pkg::CAPACITY + 8;
	localparam int             HOLD_OFF_LEN = 300;
	localparam mse_pkg::data_t DATA_MIN     = 32'sh8000_0000;
	localparam mse_pkg::data_t DATA_MAX     = 32'sh7fff_ffff;

	typedef enum int {
		MIX_WIDE,
		MIX_DUPES
	} value_mix_t;

	typedef struct packed {
		mse_pkg::data_t sorted_value;
		logic           is_final;
		logic           overflow;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	mse_in_if  in_ch ();
	mse_out_if out_ch ();

	merge_sort_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state
	mse_pkg::data_t held_words [mse_pkg::CAPACITY];
	mse_pkg::data_t merge_buf [mse_pkg::CAPACITY];
	int             held_count;
	bit             held_overflow;
	sorted_word_t   sorted_words_due [$];

	int mismatches;
	int words_sent;
	int cycle_count;
	int hold_off_len;
	int rx_low_left;
	bit tx_steady;
	bit rx_steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// runaway guard
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles", cycle_count);
		$display("testbench failed");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 2);
		if (r < 19)
			return $urandom_range(3, 6);
		return $urandom_range(20, 40);
	endfunction

	function automatic mse_pkg::data_t pick_value(value_mix_t mix);
		int r;
		r = $urandom_range(0, 9);
		if (mix == MIX_DUPES || r >= 7)
			return mse_pkg::data_t'(int'($urandom_range(0, 6)) - 3);
		if (r == 6) begin
			case ($urandom_range(0, 4))
				0: return DATA_MIN;
				1: return DATA_MAX;
				2: return mse_pkg::data_t'(0);
				3: return mse_pkg::data_t'(-1);
				default: return mse_pkg::data_t'(1);
			endcase
		end
		return mse_pkg::data_t'($urandom());
	endfunction

	// bottom-up merge of held_words[0..held_count), left run wins ties
	function automatic void merge_sort_held();
		int width, lo, mid, hi, i, j, k;
		for (width = 1; width < held_count; width *= 2) begin
			for (lo = 0; lo < held_count; lo += 2 * width) begin
				mid = (lo + width > held_count) ? held_count : lo + width;
				hi  = (lo + 2 * width > held_count) ? held_count : lo + 2 * width;
				i = lo;
				j = mid;
				for (k = lo; k < hi; k++) begin
					if (j >= hi || (i < mid && held_words[i] <= held_words[j])) begin
						merge_buf[k] = held_words[i];
						i++;
					end else begin
						merge_buf[k] = held_words[j];
						j++;
					end
				end
			end
			for (k = 0; k < held_count; k++)
				held_words[k] = merge_buf[k];
		end
	endfunction

	// one accepted input word; a closing word releases the sorted batch
	function automatic void take_word(mse_pkg::data_t value, logic is_last);
		sorted_word_t w;
		int k;
		if (held_count < mse_pkg::CAPACITY) begin
			held_words[held_count] = value;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (is_last) begin
			merge_sort_held();
			for (k = 0; k < held_count; k++) begin
				w.sorted_value = held_words[k];
				w.is_final     = (k == held_count - 1);
				w.overflow     = held_overflow;
				sorted_words_due.push_back(w);
			end
			held_count    = 0;
			held_overflow = 1'b0;
		end
	endfunction

	task automatic check_sorted_word();
		sorted_word_t got;
		sorted_word_t want;
		got.sorted_value = out_ch.sorted_value;
		got.is_final     = out_ch.is_final;
		got.overflow     = out_ch.overflow;
		if (sorted_words_due.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: unexpected word value=%0d final=%b ovf=%b", $realtime,
					got.sorted_value, got.is_final, got.overflow);
			mismatches++;
			return;
		end
		want = sorted_words_due.pop_front();
		if (got.sorted_value !== want.sorted_value || got.is_final !== want.is_final ||
			got.overflow !== want.overflow) begin
			if (mismatches < 10)
				$display("%0t: mismatch exp value=%0d final=%b ovf=%b, %s",
					$realtime, want.sorted_value, want.is_final, want.overflow,
					$sformatf("got value=%0d final=%b ovf=%b",
					got.sorted_value, got.is_final, got.overflow));
			mismatches++;
		end
	endtask

	// both handshakes are sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				take_word(in_ch.value, in_ch.is_last);
			if (out_ch.valid && out_ch.ready)
				check_sorted_word();
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		out_ch.ready = 1'b0;
		rx_low_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_off_len != 0) begin
				out_ch.ready = 1'b0;
				repeat (hold_off_len - 1) @(negedge clk);
				hold_off_len = 0;
			end else if (rx_low_left != 0) begin
				out_ch.ready = 1'b0;
				rx_low_left--;
			end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
				out_ch.ready = 1'b0;
				rx_low_left  = pick_gap() - 1;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_word(mse_pkg::data_t value, logic is_last);
		int gap;
		@(negedge clk);
		in_ch.valid   = 1'b1;
		in_ch.value   = value;
		in_ch.is_last = is_last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		words_sent++;
		gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_batch(int n, value_mix_t mix);
		int i;
		for (i = 0; i < n; i++)
			send_word(pick_value(mix), i == n - 1);
	endtask

	task automatic wait_all_sorted();
		while (sorted_words_due.size() != 0)
			@(posedge clk);
	endtask

	// single-word batches, extremes, duplicates, reversed and sorted input
	task automatic test_edges();
		send_word(DATA_MIN, 1'b1);
		send_word(DATA_MAX, 1'b1);
		send_word(mse_pkg::data_t'(7), 1'b0);
		send_word(mse_pkg::data_t'(-7), 1'b1);
		send_word(DATA_MAX, 1'b0);
		send_word(DATA_MIN, 1'b0);
		send_word(mse_pkg::data_t'(0), 1'b0);
		send_word(mse_pkg::data_t'(-1), 1'b0);
		send_word(mse_pkg::data_t'(1), 1'b0);
		send_word(mse_pkg::data_t'(0), 1'b0);
		send_word(DATA_MIN, 1'b0);
		send_word(DATA_MAX, 1'b1);
		repeat (4) send_word(mse_pkg::data_t'(-3), 1'b0);
		send_word(mse_pkg::data_t'(-3), 1'b1);
		send_word(mse_pkg::data_t'(-2), 1'b0);
		send_word(mse_pkg::data_t'(0), 1'b0);
		send_word(mse_pkg::data_t'(5), 1'b1);
	endtask

	// full row, closing word dropped, and a few words dropped before it
	task automatic test_capacity();
		send_batch(mse_pkg::CAPACITY, MIX_WIDE);
		send_batch(mse_pkg::CAPACITY + 1, MIX_WIDE);
		send_batch(mse_pkg::CAPACITY + 3, MIX_DUPES);
	endtask

	// long output stall while the next batch is already offered
	task automatic test_output_hold_off();
		@(posedge clk);
		hold_off_len = HOLD_OFF_LEN;
		send_batch(24, MIX_WIDE);
		send_batch(24, MIX_DUPES);
	endtask

	task automatic test_drain_pause();
		send_batch(5, MIX_WIDE);
		wait_all_sorted();
		send_batch(6, MIX_DUPES);
		wait_all_sorted();
	endtask

	// mostly small batches, some medium, a few at or over capacity
	task automatic test_random_batches();
		int start, r, n;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			rx_steady = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 19);
			if (r < 12)
				n = $urandom_range(1, 8);
			else if (r < 18)
				n = $urandom_range(9, 24);
			else if (r == 18)
				n = mse_pkg::CAPACITY;
			else
				n = $urandom_range(mse_pkg::CAPACITY + 1, mse_pkg::CAPACITY + 4);
			send_batch(n, ($urandom_range(0, 3) == 0) ? MIX_DUPES : MIX_WIDE);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.value   = '0;
		in_ch.is_last = 1'b0;
		held_count    = 0;
		held_overflow = 1'b0;
		mismatches    = 0;
		words_sent    = 0;
		hold_off_len  = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_edges();
		test_capacity();
		test_output_hold_off();
		test_drain_pause();
		test_random_batches();

		@(negedge clk);
		in_ch.valid = 1'b0;
		wait_all_sorted();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatches == 0 && sorted_words_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
